>>> rtl/idsd_pkg.sv
// Shared types, constants and calendar tables for the inclusive date span block.
package idsd_pkg;

	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int YEAR_W  = 14;
	localparam int DNUM_W  = 23;
	localparam int SPAN_W  = 22;
	localparam int CFG_W   = 14;

	localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1000;
	localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd9999;
	localparam logic [SPAN_W-1:0] SPAN_MAX     = {SPAN_W{1'b1}};

	// configuration register indexes
	localparam logic CFG_MIN_YEAR = 1'b0;
	localparam logic CFG_MAX_YEAR = 1'b1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FIRST_BAD  = 2'd1,
		ST_SECOND_BAD = 2'd2,
		ST_ORDER      = 2'd3
	} status_t;

	// what one lane hands to the merge stage
	typedef struct packed {
		logic              ok;
		logic [DNUM_W-1:0] dnum;
	} lane_res_t;

	function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [8:0] n;
		case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

	// floor(x / 100) by reciprocal, exact for x below 25600
	function automatic logic [7:0] div100(input logic [14:0] x);
		logic [27:0] p;
		p = 28'(x) * 28'd5243;
		return p[26:19];
	endfunction

	// floor(x / 400) as floor(floor(x / 16) / 25), exact for x below 25600
	function automatic logic [5:0] div400(input logic [14:0] x);
		logic [10:0] t;
		logic [21:0] p;
		t = x[14:4];
		p = 22'(t) * 22'd1311;
		return p[20:15];
	endfunction

endpackage

>>> rtl/inclusive_date_span_days.sv
// Top level of the inclusive date span block: lanes, merge, pipeline control and registers.
//
// Usage
//   Input channel (in_valid / in_stall) carries one request: two Gregorian
//   dates, each as month, day and year. Output channel (out_valid /
//   out_stall) returns span_days, the day count from first to second date
//   with both end days counted, and status (ok, first bad, second bad,
//   out of order). span_days is zero unless status is ok.
//   Configuration: cfg_we writes cfg_data into min_year (index 0) or
//   max_year (index 1); write only while no request is in flight.
// Timing
//   Each request passes through two stages in each date lane (year
//   arithmetic, then checks and day number) and one merge stage that
//   registers the result. One request is taken per cycle while in_stall is low.
// Reset and stall
//   arst_n clears all stage valids and loads min_year 1000, max_year 9999.
//   When out_stall holds a result, the stages behind it keep advancing into
//   empty slots; in_stall rises only once all three stages are occupied.
module inclusive_date_span_days (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [idsd_pkg::MONTH_W-1:0]     first_month,
	input  logic [idsd_pkg::DAY_W-1:0]       first_day,
	input  logic [idsd_pkg::YEAR_W-1:0]      first_year,
	input  logic [idsd_pkg::MONTH_W-1:0]     second_month,
	input  logic [idsd_pkg::DAY_W-1:0]       second_day,
	input  logic [idsd_pkg::YEAR_W-1:0]      second_year,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [idsd_pkg::SPAN_W-1:0]      span_days,
	output logic [1:0]                       status,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [idsd_pkg::CFG_W-1:0]       cfg_data
);
	import idsd_pkg::*;

	// configuration registers
	logic [YEAR_W-1:0] min_year_q;
	logic [YEAR_W-1:0] max_year_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= MIN_YEAR_RST;
			max_year_q <= MAX_YEAR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_YEAR: min_year_q <= cfg_data;
				CFG_MAX_YEAR: max_year_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valids and enables: a stage advances when it is empty or
	// when the stage ahead of it advances
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic en_s1;
	logic en_s2;
	logic en_s3;

	assign en_s3    = !valid_s3 || !out_stall;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// one lane per date
	lane_res_t first_res_s2;
	lane_res_t second_res_s2;

	idsd_lane u_lane_first (
		.clk      (clk),
		.en_s1    (en_s1),
		.en_s2    (en_s2),
		.month    (first_month),
		.day      (first_day),
		.year     (first_year),
		.min_year (min_year_q),
		.max_year (max_year_q),
		.res_s2   (first_res_s2)
	);

	idsd_lane u_lane_second (
		.clk      (clk),
		.en_s1    (en_s1),
		.en_s2    (en_s2),
		.month    (second_month),
		.day      (second_day),
		.year     (second_year),
		.min_year (min_year_q),
		.max_year (max_year_q),
		.res_s2   (second_res_s2)
	);

	// merge both lanes into the output register
	status_t status_q;

	idsd_merge u_merge (
		.clk        (clk),
		.en         (en_s3),
		.first_res  (first_res_s2),
		.second_res (second_res_s2),
		.span_q     (span_days),
		.status_q   (status_q)
	);

	assign status    = status_q;
	assign out_valid = valid_s3;

endmodule

>>> rtl/idsd_lane.sv
// One date lane: checks a date and forms its day number over two stages.
module idsd_lane (
	input  logic                             clk,
	input  logic                             en_s1,
	input  logic                             en_s2,
	input  logic [idsd_pkg::MONTH_W-1:0]     month,
	input  logic [idsd_pkg::DAY_W-1:0]       day,
	input  logic [idsd_pkg::YEAR_W-1:0]      year,
	input  logic [idsd_pkg::YEAR_W-1:0]      min_year,
	input  logic [idsd_pkg::YEAR_W-1:0]      max_year,
	output idsd_pkg::lane_res_t              res_s2
);
	import idsd_pkg::*;

	logic [MONTH_W-1:0] month_s1;
	logic [DAY_W-1:0]   day_s1;
	logic [YEAR_W-1:0]  year_s1;
	logic [7:0]         q100_s1;
	logic [7:0]         c100_s1;
	logic [5:0]         c400_s1;
	logic [DNUM_W-1:0]  y365_s1;

	logic [14:0] year_x;
	logic [14:0] y99;
	logic [14:0] y399;

	assign year_x = {1'b0, year};
	assign y99    = year_x + 15'd99;
	assign y399   = year_x + 15'd399;

	// stage 1: constant multiplies and divides of the year
	always_ff @(posedge clk) begin
		if (en_s1) begin
			month_s1 <= month;
			day_s1   <= day;
			year_s1  <= year;
			q100_s1  <= div100(year_x);
			c100_s1  <= div100(y99);
			c400_s1  <= div400(y399);
			y365_s1  <= DNUM_W'(year) * 23'd365;
		end
	end

	logic [14:0]       cent_x100;
	logic              cent_year;
	logic              leap;
	logic [DAY_W-1:0]  mlen;
	logic              ok;
	logic [14:0]       y3;
	logic [DNUM_W-1:0] dnum;

	assign cent_x100 = 15'(q100_s1 * 15'd100);
	assign cent_year = (cent_x100 == {1'b0, year_s1});
	// leap: divisible by 4, and either not a century or a century divisible by 4
	assign leap = (year_s1[1:0] == 2'd0) && (!cent_year || (q100_s1[1:0] == 2'd0));

	always_comb begin
		mlen = days_in_month(month_s1);
		if (month_s1 == 4'd2 && leap) begin
			mlen = 5'd29;
		end
	end

	assign ok = (month_s1 >= 4'd1) && (month_s1 <= 4'd12) && (day_s1 != '0)
		&& (day_s1 <= mlen) && (year_s1 >= min_year) && (year_s1 <= max_year);

	assign y3 = {1'b0, year_s1} + 15'd3;

	assign dnum = y365_s1 + DNUM_W'(y3[14:2]) - DNUM_W'(c100_s1) + DNUM_W'(c400_s1)
		+ DNUM_W'(days_before_month(month_s1))
		+ DNUM_W'((month_s1 > 4'd2) && leap) + DNUM_W'(day_s1) - 23'd1;

	// stage 2: hold validity and day number for the merge
	always_ff @(posedge clk) begin
		if (en_s2) begin
			res_s2.ok   <= ok;
			res_s2.dnum <= dnum;
		end
	end

endmodule

>>> rtl/idsd_merge.sv
// Merge stage: orders the two day numbers, forms the inclusive span and status.
module idsd_merge (
	input  logic                          clk,
	input  logic                          en,
	input  idsd_pkg::lane_res_t           first_res,
	input  idsd_pkg::lane_res_t           second_res,
	output logic [idsd_pkg::SPAN_W-1:0]   span_q,
	output idsd_pkg::status_t             status_q
);
	import idsd_pkg::*;

	logic              reversed;
	logic [DNUM_W:0]   diff;
	logic [SPAN_W-1:0] span;
	status_t           status;

	assign reversed = second_res.dnum < first_res.dnum;
	assign diff     = {1'b0, second_res.dnum} - {1'b0, first_res.dnum} + 24'd1;

	always_comb begin
		span = '0;
		if (!first_res.ok) begin
			status = ST_FIRST_BAD;
		end else if (!second_res.ok) begin
			status = ST_SECOND_BAD;
		end else if (reversed) begin
			status = ST_ORDER;
		end else begin
			status = ST_OK;
			// clamp spans that the year registers allow beyond the field
			if (diff > {2'b00, SPAN_MAX}) begin
				span = SPAN_MAX;
			end else begin
				span = diff[SPAN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			span_q   <= span;
			status_q <= status;
		end
	end

endmodule

>>> rtl/idsd_checker.sv
// Port-level checker for the inclusive date span block, bound to the top level.
module idsd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [idsd_pkg::SPAN_W-1:0]    span_days,
	input logic [1:0]                     status
);
	import idsd_pkg::*;

	// hold a stalled result unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(span_days) && $stable(status))
		else $error("stalled result changed");

	// a failed request reports no span
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> span_days == '0)
		else $error("span not zero on error status");

	// a good request always counts at least one day
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK) |-> span_days != '0)
		else $error("zero span with ok status");

	// back-pressure only comes from a stalled, occupied output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

endmodule

bind inclusive_date_span_days idsd_checker u_idsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.span_days (span_days),
	.status    (status)
);

>>> verif/testbench.sv
// Self-checking testbench for the inclusive date span block.
`timescale 1ns / 1ps

module testbench;
	import idsd_pkg::*;

	// one calendar date as the block sees it
	typedef struct packed {
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [YEAR_W-1:0]  year;
	} date_t;

	// one request: a pair of dates
	typedef struct packed {
		date_t first;
		date_t second;
	} date_pair_t;

	// what a request should come back as
	typedef struct {
		logic [SPAN_W-1:0] span;
		status_t           code;
	} span_entry_t;

	// Scoreboard: holds its own copy of the year window, works out the span for
	// every accepted request and checks results against them in order.
	class date_span_book;
		int unsigned year_lo;
		int unsigned year_hi;
		int unsigned mismatches;
		span_entry_t awaited_spans[$];

		function new();
			year_lo     = MIN_YEAR_RST;
			year_hi     = MAX_YEAR_RST;
			mismatches  = 0;
		endfunction

		function bit is_leap(int unsigned y);
			return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
		endfunction

		function int unsigned month_length(int unsigned m, int unsigned y);
			case (m)
				1, 3, 5, 7, 8, 10, 12: return 31;
				4, 6, 9, 11:           return 30;
				2:                     return is_leap(y) ? 29 : 28;
				default:               return 0;
			endcase
		endfunction

		function bit date_valid(date_t dt);
			int unsigned len;
			len = month_length(dt.month, dt.year);
			if (len == 0 || dt.day == 0 || dt.day > len)
				return 1'b0;
			return dt.year >= year_lo && dt.year <= year_hi;
		endfunction

		// days since 1 January of year 0, year 0 being a leap year
		function int unsigned day_index(date_t dt);
			int unsigned y;
			int unsigned n;
			y = dt.year;
			n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
			for (int unsigned k = 1; k < dt.month; k++)
				n += month_length(k, y);
			return n + dt.day - 1;
		endfunction

		function span_entry_t predict_span(date_pair_t r);
			span_entry_t e;
			int unsigned a;
			int unsigned b;
			e.span = '0;
			if (!date_valid(r.first)) begin
				e.code = ST_FIRST_BAD;
			end else if (!date_valid(r.second)) begin
				e.code = ST_SECOND_BAD;
			end else begin
				a = day_index(r.first);
				b = day_index(r.second);
				if (b < a) begin
					e.code = ST_ORDER;
				end else begin
					e.code = ST_OK;
					e.span = (b - a + 1 > SPAN_MAX) ? SPAN_MAX : SPAN_W'(b - a + 1);
				end
			end
			return e;
		endfunction

		function void note_request(date_pair_t r);
			awaited_spans.push_back(predict_span(r));
		endfunction

		function int pending();
			return awaited_spans.size();
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $time, what);
			mismatches++;
		endtask

		task check_result(logic [SPAN_W-1:0] span, logic [1:0] code);
			span_entry_t e;
			if (awaited_spans.size() == 0) begin
				report($sformatf("result span=%0d status=%0d with nothing awaited",
					span, code));
			end else begin
				e = awaited_spans.pop_front();
				if (span !== e.span)
					report($sformatf("span_days %0d, predicted %0d", span, e.span));
				if (code !== e.code)
					report($sformatf("status %0d, predicted %s", code, e.code.name()));
			end
		endtask
	endclass

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic [MONTH_W-1:0]  first_month  = '0;
	logic [DAY_W-1:0]    first_day    = '0;
	logic [YEAR_W-1:0]   first_year   = '0;
	logic [MONTH_W-1:0]  second_month = '0;
	logic [DAY_W-1:0]    second_day   = '0;
	logic [YEAR_W-1:0]   second_year  = '0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic [SPAN_W-1:0]   span_days;
	logic [1:0]          status;
	logic                cfg_we       = 1'b0;
	logic                cfg_index    = CFG_MIN_YEAR;
	logic [CFG_W-1:0]    cfg_data     = '0;

	date_span_book sb = new();

	// sender burst bookkeeping
	int burst_left = 0;

	// receiver stall pattern
	int stall_mode = 0;
	int stall_left = 0;
	int stall_tick = 0;

	inclusive_date_span_days i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.first_month  (first_month),
		.first_day    (first_day),
		.first_year   (first_year),
		.second_month (second_month),
		.second_day   (second_day),
		.second_year  (second_year),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.span_days    (span_days),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: switch between a handful of stall habits - never stall, stall
	// rarely, stall mostly, and a fixed rhythm - so that back-pressure lands on
	// every stage of the pipeline.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(3);
			stall_left <= $urandom_range(80, 20);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(3) == 0);
			2:       out_stall <= ($urandom_range(3) != 0);
			default: out_stall <= ((stall_tick % 7) < 3);
		endcase
	end

	// Monitor: take a result on every edge where it is offered and not held.
	// Values are read before this edge's updates land, i.e. as the block saw them.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(span_days, status);
	end

	// Give up well beyond the slowest legal run.
	initial begin
		#(20_000_000);
		$display("== FAIL ==");
		$finish;
	end

	// drop valid for a number of cycles
	task automatic hold_off(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// drop valid and wait until every outstanding request has come back;
	// the wait is made before the check, so valid is never lowered and raised
	// within the same step
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// write one register with the pipeline empty; allow for the three-stage
	// latency before touching the window
	task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
		wait_for_drain();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MIN_YEAR)
			sb.year_lo = value;
		else
			sb.year_hi = value;
	endtask

	task automatic set_year_window(int unsigned lo, int unsigned hi);
		write_reg(CFG_MIN_YEAR, CFG_W'(lo));
		write_reg(CFG_MAX_YEAR, CFG_W'(hi));
	endtask

	// Drive one request and hold it until accepted. Work in bursts: at the end
	// of each burst pause for a random gap, now and then skip the gap so that
	// long unbroken stretches happen too.
	task automatic push_request(date_pair_t r);
		if (burst_left == 0) begin
			if ($urandom_range(3) != 0)
				hold_off($urandom_range(6, 1));
			burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 30)
			                                      : $urandom_range(12, 1);
		end
		burst_left--;
		in_valid     <= 1'b1;
		first_month  <= r.first.month;
		first_day    <= r.first.day;
		first_year   <= r.first.year;
		second_month <= r.second.month;
		second_day   <= r.second.day;
		second_year  <= r.second.year;
		do @(posedge clk); while (in_stall);
		sb.note_request(r);
	endtask

	function automatic date_pair_t pair_of(int m1, int d1, int y1, int m2, int d2, int y2);
		date_pair_t r;
		r.first  = '{MONTH_W'(m1), DAY_W'(d1), YEAR_W'(y1)};
		r.second = '{MONTH_W'(m2), DAY_W'(d2), YEAR_W'(y2)};
		return r;
	endfunction

	// year biased towards the window edges; any year if the window is empty
	function automatic int unsigned pick_year();
		int unsigned roll;
		roll = $urandom_range(99);
		if (sb.year_lo > sb.year_hi)
			return $urandom_range(16383);
		if (roll < 8)
			return sb.year_lo;
		if (roll < 16)
			return sb.year_hi;
		return $urandom_range(sb.year_hi, sb.year_lo);
	endfunction

	function automatic date_t valid_date();
		date_t dt;
		dt.year  = YEAR_W'(pick_year());
		dt.month = MONTH_W'($urandom_range(12, 1));
		dt.day   = DAY_W'($urandom_range(sb.month_length(dt.month, dt.year), 1));
		return dt;
	endfunction

	// a date that is broken in one way, or just raw bits; under the full year window the year case leaves it valid
	function automatic date_t broken_date();
		date_t dt;
		int unsigned len;
		dt  = valid_date();
		len = sb.month_length(dt.month, dt.year);
		case ($urandom_range(5))
			0: dt.day = (len < 31) ? DAY_W'($urandom_range(31, len + 1)) : '0;
			1: dt.month = ($urandom_range(1) == 0) ? '0 : MONTH_W'($urandom_range(15, 13));
			2: dt.day = '0;
			3: begin
				if (sb.year_lo > 0)
					dt.year = YEAR_W'(sb.year_lo - 1);
				else if (sb.year_hi < 16383)
					dt.year = YEAR_W'(sb.year_hi + 1);
			end
			default: dt = date_t'($urandom);
		endcase
		return dt;
	endfunction

	// Mostly well-formed pairs, usually in order and sometimes equal; the rest
	// carries one or two broken dates.
	function automatic date_pair_t random_pair();
		date_pair_t r;
		date_t      hold;
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 70) begin
			r.first  = valid_date();
			r.second = valid_date();
			if ($urandom_range(19) == 0) begin
				r.second = r.first;
			end else if ($urandom_range(9) < 7 &&
			             sb.day_index(r.second) < sb.day_index(r.first)) begin
				hold     = r.first;
				r.first  = r.second;
				r.second = hold;
			end
		end else if (roll < 80) begin
			r.first  = valid_date();
			r.second = broken_date();
		end else if (roll < 88) begin
			r.first  = broken_date();
			r.second = valid_date();
		end else begin
			r.first  = broken_date();
			r.second = broken_date();
		end
		return r;
	endfunction

	initial begin
		date_pair_t    directed[$];
		int unsigned   window_lo[8];
		int unsigned   window_hi[8];

		// hold reset, then release it on an edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset window 1000..9999.
		directed.push_back(pair_of( 1,  1, 2000,  1,  1, 2000)); // equal dates
		directed.push_back(pair_of( 2, 29, 2000,  3,  1, 2000)); // leap by 400
		directed.push_back(pair_of( 2, 29, 1900,  3,  1, 1900)); // century, no leap
		directed.push_back(pair_of( 1,  1, 2023,  2, 29, 2023)); // second bad
		directed.push_back(pair_of( 0,  5, 2000,  1,  1, 2001)); // month zero
		directed.push_back(pair_of(13,  1, 2000,  1,  1, 2001)); // month past 12
		directed.push_back(pair_of(15, 31, 16383, 15, 31, 16383)); // both bad, all ones
		directed.push_back(pair_of( 4, 31, 2000,  5,  1, 2000)); // day past month end
		directed.push_back(pair_of( 1,  0, 2000,  1,  1, 2000)); // day zero
		directed.push_back(pair_of( 1,  1,  999,  1,  1, 2000)); // below window
		directed.push_back(pair_of( 1,  1, 2000,  1,  1, 10000)); // above window
		directed.push_back(pair_of(12, 31, 9999,  1,  1, 1000)); // out of order
		directed.push_back(pair_of( 1,  1, 1000, 12, 31, 9999)); // full window
		directed.push_back(pair_of( 3,  1, 2001,  2, 28, 2001)); // out of order by a day
		directed.push_back(pair_of(12, 31, 1999,  1,  1, 2000)); // across a year end
		directed.push_back(pair_of( 1,  1, 2000, 12, 31, 2000)); // whole leap year
		directed.push_back(pair_of( 2, 29, 2024,  2, 29, 2028)); // leap day to leap day
		foreach (directed[k])
			push_request(directed[k]);

		// widest window: year zero is a leap year and the span saturates
		set_year_window(0, 16383);
		directed.delete();
		directed.push_back(pair_of( 2, 29,     0,  3,  1,     0));
		directed.push_back(pair_of( 1,  1,     0, 12, 31, 16383));
		directed.push_back(pair_of(12, 31, 16383, 12, 31, 16383));
		directed.push_back(pair_of( 2, 29,   100,  3,  1,   100));
		directed.push_back(pair_of( 2, 29,   400,  1,  1,   401));
		foreach (directed[k])
			push_request(directed[k]);

		// empty window: nothing is valid
		set_year_window(16383, 0);
		push_request(pair_of(1, 1, 2000, 1, 1, 2000));

		// Random part over several windows, extremes included.
		window_lo = '{1000,     0, 2000, 16383,     0, 16383, 0, 0};
		window_hi = '{9999, 16383, 2000,     0,     0, 16383, 0, 0};
		window_lo[6] = $urandom_range(16383);
		window_hi[6] = $urandom_range(16383);
		window_lo[7] = $urandom_range(3000);
		window_hi[7] = window_lo[7] + $urandom_range(400);
		for (int phase = 0; phase < 8; phase++) begin
			set_year_window(window_lo[phase], window_hi[phase]);
			for (int k = 0; k < 212; k++) begin
				// now and then let the pipeline empty completely
				if (k == 100)
					wait_for_drain();
				push_request(random_pair());
			end
		end

		// wait for the tail, then a little longer for anything stray
		wait_for_drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
